FILE: sv/rsbl_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths, reset values and register codes of the red spot locator.
// Depends on nothing; every other file takes names from here by scope.
package rsbl_pkg;

   // field widths
   localparam int PIX_W       = 8;
   localparam int COORD_W     = 11;
   localparam int POS_W       = 12;
   localparam int SCALE_W     = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // frame limits and fixed-point scale format
   localparam int MAX_WIDTH       = 2048;
   localparam int MAX_HEIGHT      = 2048;
   localparam int SCALE_FRAC_BITS = 12;

   // scaled centre widths
   localparam int PROD_W    = COORD_W + SCALE_W;
   localparam int SHIFT_W   = PROD_W - SCALE_FRAC_BITS;
   localparam int LIMIT_W   = (SHIFT_W > POS_W) ? SHIFT_W : POS_W;

   // reset values
   localparam logic [PIX_W-1:0]   DIFF_RESET       = PIX_W'(80);
   localparam logic [PIX_W-1:0]   DARK_RESET       = PIX_W'(100);
   localparam logic [SCALE_W-1:0] SCALE_RESET      = SCALE_W'(4096);
   localparam logic [POS_W-1:0]   CLAMP_LOW_RESET  = POS_W'(20);
   localparam logic [POS_W-1:0]   CLAMP_HIGH_RESET = POS_W'(380);
   localparam logic [POS_W-1:0]   POS_RESET        = POS_W'(200);

   // register index codes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DIFF_THRESHOLD = 3'd0,
      CSR_DARK_THRESHOLD = 3'd1,
      CSR_SCALE_X        = 3'd2,
      CSR_SCALE_Y        = 3'd3,
      CSR_CLAMP_LOW      = 3'd4,
      CSR_CLAMP_HIGH     = 3'd5
   } csr_index_type;

   // configuration as seen by the datapath
   typedef struct packed {
      logic [PIX_W-1:0]   diff_threshold;
      logic [PIX_W-1:0]   dark_threshold;
      logic [SCALE_W-1:0] scale_x;
      logic [SCALE_W-1:0] scale_y;
      logic [POS_W-1:0]   clamp_low;
      logic [POS_W-1:0]   clamp_high;
   } cfg_type;

   // frame summary handed from the box tracker to the scaler
   typedef struct packed {
      logic [COORD_W-1:0] cen_x;
      logic [COORD_W-1:0] cen_y;
      logic               found;
   } cen_type;

   // saturate a coordinate to lim - 1
   function automatic logic [COORD_W-1:0] sat_coord(input logic [COORD_W-1:0] v,
                                                    input int unsigned lim);
      logic [31:0] ext;
      ext = 32'(v);
      if (ext > 32'(lim - 1)) begin
         return COORD_W'(lim - 1);
      end
      return v;
   endfunction

   // clamp: high bound first, then low bound wins
   function automatic logic [POS_W-1:0] limit(input logic [LIMIT_W-1:0] v,
                                              input logic [POS_W-1:0] lo,
                                              input logic [POS_W-1:0] hi);
      logic [LIMIT_W-1:0] t;
      t = v;
      if (t >= LIMIT_W'(hi)) begin
         t = LIMIT_W'(hi);
      end
      if (t <= LIMIT_W'(lo)) begin
         t = LIMIT_W'(lo);
      end
      return t[POS_W-1:0];
   endfunction

endpackage

FILE: sv/rsbl_req_if.sv
`timescale 1ns / 1ps
// Pixel channel: valid/ready handshake with one BGR pixel and its position.
// Depends on rsbl_pkg for field widths.
interface rsbl_req_if;
   logic                        valid;
   logic                        ready;
   logic [rsbl_pkg::PIX_W-1:0]   blue;
   logic [rsbl_pkg::PIX_W-1:0]   green;
   logic [rsbl_pkg::PIX_W-1:0]   red;
   logic [rsbl_pkg::COORD_W-1:0] pix_row;
   logic [rsbl_pkg::COORD_W-1:0] pix_col;
   logic                        frame_last;

   modport source (output valid, blue, green, red, pix_row, pix_col, frame_last,
                   input ready);
   modport sink   (input valid, blue, green, red, pix_row, pix_col, frame_last,
                   output ready);
endinterface

FILE: sv/rsbl_rsp_if.sv
`timescale 1ns / 1ps
// Result channel: valid/ready handshake with the clamped spot position.
// Depends on rsbl_pkg for field widths.
interface rsbl_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [rsbl_pkg::POS_W-1:0] pos_x;
   logic [rsbl_pkg::POS_W-1:0] pos_y;
   logic                      spot_found;

   modport source (output valid, pos_x, pos_y, spot_found, input ready);
   modport sink   (input valid, pos_x, pos_y, spot_found, output ready);
endinterface

FILE: sv/rsbl_csr.sv
`timescale 1ns / 1ps
// Configuration registers of the red spot locator, written through a plain write port.
// Depends on rsbl_pkg for widths, reset values and index codes.
module rsbl_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [rsbl_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rsbl_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output rsbl_pkg::cfg_type                cfg
);

   rsbl_pkg::cfg_type cfg_ff, cfg_in;

   // decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (rsbl_pkg::csr_index_type'(csr_index))
            rsbl_pkg::CSR_DIFF_THRESHOLD:
               cfg_in.diff_threshold = csr_wdata[rsbl_pkg::PIX_W-1:0];
            rsbl_pkg::CSR_DARK_THRESHOLD:
               cfg_in.dark_threshold = csr_wdata[rsbl_pkg::PIX_W-1:0];
            rsbl_pkg::CSR_SCALE_X:    cfg_in.scale_x    = csr_wdata;
            rsbl_pkg::CSR_SCALE_Y:    cfg_in.scale_y    = csr_wdata;
            rsbl_pkg::CSR_CLAMP_LOW:  cfg_in.clamp_low  = csr_wdata[rsbl_pkg::POS_W-1:0];
            rsbl_pkg::CSR_CLAMP_HIGH: cfg_in.clamp_high = csr_wdata[rsbl_pkg::POS_W-1:0];
            default: ;
         endcase
      end
   end

   // hold the registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.diff_threshold <= rsbl_pkg::DIFF_RESET;
         cfg_ff.dark_threshold <= rsbl_pkg::DARK_RESET;
         cfg_ff.scale_x        <= rsbl_pkg::SCALE_RESET;
         cfg_ff.scale_y        <= rsbl_pkg::SCALE_RESET;
         cfg_ff.clamp_low      <= rsbl_pkg::CLAMP_LOW_RESET;
         cfg_ff.clamp_high     <= rsbl_pkg::CLAMP_HIGH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: sv/rsbl_box.sv
`timescale 1ns / 1ps
// Pixel input register, red classifier and bounding box tracker; emits the box
// centre at the end of each frame. Depends on rsbl_pkg and rsbl_req_if.
module rsbl_box (
   input  logic              clock,
   input  logic              reset,
   rsbl_req_if.sink          req_ch,
   input  rsbl_pkg::cfg_type cfg,
   output logic              cen_valid,
   input  logic              cen_ready,
   output rsbl_pkg::cen_type cen
);

   localparam int CW = rsbl_pkg::COORD_W;

   // input register
   logic                        s1_valid_ff;
   logic [rsbl_pkg::PIX_W-1:0]  s1_blue_ff, s1_green_ff, s1_red_ff;
   logic [CW-1:0]               s1_row_ff, s1_col_ff;
   logic                        s1_last_ff;

   // box state
   logic          seen_ff, seen_in;
   logic [CW-1:0] min_row_ff, min_row_in, max_row_ff, max_row_in;
   logic [CW-1:0] min_col_ff, min_col_in, max_col_ff, max_col_in;

   // centre register
   logic              s2_valid_ff;
   rsbl_pkg::cen_type s2_ff, s2_in;

   logic          s1_go, s2_free, is_red;
   logic [CW-1:0] row, col;
   logic [CW-1:0] m_min_row, m_max_row, m_min_col, m_max_col;
   logic          m_seen;
   logic [CW:0]   sum_x, sum_y;

   assign s2_free      = !s2_valid_ff || cen_ready;
   assign s1_go        = s1_valid_ff && (!s1_last_ff || s2_free);
   assign req_ch.ready = !s1_valid_ff || s1_go;

   // classify the held pixel
   always_comb begin
      row    = rsbl_pkg::sat_coord(s1_row_ff, rsbl_pkg::MAX_HEIGHT);
      col    = rsbl_pkg::sat_coord(s1_col_ff, rsbl_pkg::MAX_WIDTH);
      is_red = ({1'b0, s1_red_ff} > {1'b0, s1_blue_ff} + {1'b0, cfg.diff_threshold})
            && ({1'b0, s1_red_ff} > {1'b0, s1_green_ff} + {1'b0, cfg.diff_threshold})
            && (s1_green_ff < cfg.dark_threshold)
            && (s1_blue_ff < cfg.dark_threshold);
   end

   // merge the pixel into the box; the first red pixel opens it
   always_comb begin
      m_seen    = seen_ff;
      m_min_row = min_row_ff;
      m_max_row = max_row_ff;
      m_min_col = min_col_ff;
      m_max_col = max_col_ff;
      if (is_red) begin
         m_seen = 1'b1;
         if (!seen_ff) begin
            m_min_row = row;
            m_max_row = row;
            m_min_col = col;
            m_max_col = col;
         end else begin
            if (row < min_row_ff) m_min_row = row;
            if (row > max_row_ff) m_max_row = row;
            if (col < min_col_ff) m_min_col = col;
            if (col > max_col_ff) m_max_col = col;
         end
      end
      sum_x = {1'b0, m_min_col} + {1'b0, m_max_col};
      sum_y = {1'b0, m_min_row} + {1'b0, m_max_row};
   end

   // advance the box; clear it after the last pixel of a frame
   always_comb begin
      seen_in    = seen_ff;
      min_row_in = min_row_ff;
      max_row_in = max_row_ff;
      min_col_in = min_col_ff;
      max_col_in = max_col_ff;
      if (s1_go) begin
         if (s1_last_ff) begin
            seen_in    = 1'b0;
            min_row_in = '1;
            max_row_in = '0;
            min_col_in = '1;
            max_col_in = '0;
         end else begin
            seen_in    = m_seen;
            min_row_in = m_min_row;
            max_row_in = m_max_row;
            min_col_in = m_min_col;
            max_col_in = m_max_col;
         end
      end
      s2_in.cen_x = sum_x[CW:1];
      s2_in.cen_y = sum_y[CW:1];
      s2_in.found = m_seen;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         seen_ff     <= 1'b0;
         min_row_ff  <= '1;
         max_row_ff  <= '0;
         min_col_ff  <= '1;
         max_col_ff  <= '0;
      end else begin
         if (req_ch.ready) s1_valid_ff <= req_ch.valid;
         if (s2_free)      s2_valid_ff <= s1_go && s1_last_ff;
         seen_ff    <= seen_in;
         min_row_ff <= min_row_in;
         max_row_ff <= max_row_in;
         min_col_ff <= min_col_in;
         max_col_ff <= max_col_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         s1_blue_ff  <= req_ch.blue;
         s1_green_ff <= req_ch.green;
         s1_red_ff   <= req_ch.red;
         s1_row_ff   <= req_ch.pix_row;
         s1_col_ff   <= req_ch.pix_col;
         s1_last_ff  <= req_ch.frame_last;
      end
      if (s2_free && s1_go && s1_last_ff) begin
         s2_ff <= s2_in;
      end
   end

   assign cen_valid = s2_valid_ff;
   assign cen       = s2_ff;

   a_box_ordered: assert property (@(posedge clock) disable iff (reset)
      seen_ff |-> (min_row_ff <= max_row_ff) && (min_col_ff <= max_col_ff))
      else $error("bounding box inverted while a red pixel is held");
   a_frame_clears: assert property (@(posedge clock) disable iff (reset)
      s1_go && s1_last_ff |=> !seen_ff)
      else $error("box not cleared after the last pixel of a frame");
   a_centre_held: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !cen_ready |=> s2_valid_ff && $stable(s2_ff))
      else $error("pending frame centre lost or changed");

endmodule

FILE: sv/rsbl_scale.sv
`timescale 1ns / 1ps
// Scaling multiplier, clamp, remembered position and result register.
// Depends on rsbl_pkg and rsbl_rsp_if.
module rsbl_scale (
   input  logic              clock,
   input  logic              reset,
   input  rsbl_pkg::cfg_type cfg,
   input  logic              cen_valid,
   output logic              cen_ready,
   input  rsbl_pkg::cen_type cen,
   rsbl_rsp_if.source        rsp_ch
);

   localparam int PW = rsbl_pkg::PROD_W;
   localparam int LW = rsbl_pkg::LIMIT_W;
   localparam int QW = rsbl_pkg::POS_W;

   // product stage
   logic          p_valid_ff;
   logic [PW-1:0] prod_x_ff, prod_y_ff;
   logic          p_found_ff;

   // result stage and remembered position
   logic          rsp_valid_ff;
   logic [QW-1:0] pos_x_ff, pos_y_ff, pos_x_in, pos_y_in;
   logic          found_ff;
   logic [QW-1:0] last_x_ff, last_y_ff;

   logic          out_free, p_free;
   logic [LW-1:0] vx, vy;

   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign p_free    = !p_valid_ff || out_free;
   assign cen_ready = p_free;

   // pick the scaled centre or the previous position, then clamp
   always_comb begin
      if (p_found_ff) begin
         vx = LW'(prod_x_ff >> rsbl_pkg::SCALE_FRAC_BITS);
         vy = LW'(prod_y_ff >> rsbl_pkg::SCALE_FRAC_BITS);
      end else begin
         vx = LW'(last_x_ff);
         vy = LW'(last_y_ff);
      end
      pos_x_in = rsbl_pkg::limit(vx, cfg.clamp_low, cfg.clamp_high);
      pos_y_in = rsbl_pkg::limit(vy, cfg.clamp_low, cfg.clamp_high);
   end

   // control and remembered position
   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         last_x_ff    <= rsbl_pkg::POS_RESET;
         last_y_ff    <= rsbl_pkg::POS_RESET;
      end else begin
         if (p_free)   p_valid_ff   <= cen_valid;
         if (out_free) rsp_valid_ff <= p_valid_ff;
         if (out_free && p_valid_ff) begin
            last_x_ff <= pos_x_in;
            last_y_ff <= pos_y_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (p_free && cen_valid) begin
         prod_x_ff  <= PW'(cen.cen_x) * PW'(cfg.scale_x);
         prod_y_ff  <= PW'(cen.cen_y) * PW'(cfg.scale_y);
         p_found_ff <= cen.found;
      end
      if (out_free && p_valid_ff) begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         found_ff <= p_found_ff;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.pos_x      = pos_x_ff;
   assign rsp_ch.pos_y      = pos_y_ff;
   assign rsp_ch.spot_found = found_ff;

   a_pos_remembered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (pos_x_ff == last_x_ff) && (pos_y_ff == last_y_ff))
      else $error("pending result differs from the remembered position");
   a_prod_held: assert property (@(posedge clock) disable iff (reset)
      p_valid_ff && !out_free |=> p_valid_ff && $stable(prod_x_ff) && $stable(prod_y_ff))
      else $error("product stage changed while blocked");

endmodule

FILE: sv/red_spot_bbox_locator.sv
`timescale 1ns / 1ps
// Red spot locator: finds the bounding box of red pixels over a frame and
// reports its scaled, clamped centre once per frame.
//
// Channels: req_ch carries one BGR pixel per item with its row, column and a
// frame_last mark; rsp_ch carries one item per frame (pos_x, pos_y,
// spot_found), issued for the pixel marked frame_last. Both use valid/ready.
// csr_* is a write-only register port (index 0..5: diff and dark thresholds,
// x and y scale in Q4.12, low and high clamp); write it only while idle.
// Throughput: one pixel per cycle while not stalled, set by the combinational
// compare and merge of the box registers. Path: a frame_last pixel passes the
// input register, the centre register, one 11x16 multiplier per axis into the
// product register, then clamp into the result register.
// Reset: synchronous; registers return to their reset values, the box is
// empty and the remembered position is 200 on both axes.
// Stall: a waiting result does not block pixels that are not frame_last;
// a frame_last pixel waits only while the centre, product and result
// registers are all full and the result is not taken.
module red_spot_bbox_locator (
   input  logic                             clock,
   input  logic                             reset,
   rsbl_req_if.sink                         req_ch,
   rsbl_rsp_if.source                       rsp_ch,
   input  logic                             csr_wr_en,
   input  logic [rsbl_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rsbl_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   rsbl_pkg::cfg_type cfg;
   rsbl_pkg::cen_type cen;
   logic              cen_valid, cen_ready;

   // configuration registers
   rsbl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // classify and track the box
   rsbl_box u_box (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .cfg       (cfg),
      .cen_valid (cen_valid),
      .cen_ready (cen_ready),
      .cen       (cen)
   );

   // scale, clamp and deliver
   rsbl_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cen_valid (cen_valid),
      .cen_ready (cen_ready),
      .cen       (cen),
      .rsp_ch    (rsp_ch)
   );

endmodule

FILE: verif/red_spot_bbox_locator_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for red_spot_bbox_locator: streams pixel frames under several
// register settings and checks every spot result against an in-bench box tracker.
// Depends on rsbl_pkg, rsbl_req_if, rsbl_rsp_if and the locator RTL.
module red_spot_bbox_locator_tb;

   typedef struct {
      logic [rsbl_pkg::PIX_W-1:0]   blue;
      logic [rsbl_pkg::PIX_W-1:0]   green;
      logic [rsbl_pkg::PIX_W-1:0]   red;
      logic [rsbl_pkg::COORD_W-1:0] row;
      logic [rsbl_pkg::COORD_W-1:0] col;
      logic                         last;
   } pixel_item_type;

   typedef struct {
      logic [rsbl_pkg::POS_W-1:0] pos_x;
      logic [rsbl_pkg::POS_W-1:0] pos_y;
      logic                       found;
   } spot_type;

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             csr_wr_en;
   logic [rsbl_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [rsbl_pkg::CSR_DATA_W-1:0]  csr_wdata;

   rsbl_req_if req_ch ();
   rsbl_rsp_if rsp_ch ();

   red_spot_bbox_locator i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // register mirror
   logic [rsbl_pkg::PIX_W-1:0]   cfg_diff       = rsbl_pkg::DIFF_RESET;
   logic [rsbl_pkg::PIX_W-1:0]   cfg_dark       = rsbl_pkg::DARK_RESET;
   logic [rsbl_pkg::SCALE_W-1:0] cfg_scale_x    = rsbl_pkg::SCALE_RESET;
   logic [rsbl_pkg::SCALE_W-1:0] cfg_scale_y    = rsbl_pkg::SCALE_RESET;
   logic [rsbl_pkg::POS_W-1:0]   cfg_clamp_low  = rsbl_pkg::CLAMP_LOW_RESET;
   logic [rsbl_pkg::POS_W-1:0]   cfg_clamp_high = rsbl_pkg::CLAMP_HIGH_RESET;

   // bounding box tracker state
   logic [rsbl_pkg::COORD_W-1:0] box_min_row = '1;
   logic [rsbl_pkg::COORD_W-1:0] box_min_col = '1;
   logic [rsbl_pkg::COORD_W-1:0] box_max_row = '0;
   logic [rsbl_pkg::COORD_W-1:0] box_max_col = '0;
   logic                         box_seen    = 1'b0;
   logic [rsbl_pkg::POS_W-1:0]   prev_x      = rsbl_pkg::POS_RESET;
   logic [rsbl_pkg::POS_W-1:0]   prev_y      = rsbl_pkg::POS_RESET;

   pixel_item_type pending_pixels[$];
   spot_type       expected_spots[$];
   pixel_item_type drive_pixel;
   pixel_item_type taken_pixel;
   spot_type       wanted_spot;
   int             pixels_queued  = 0;
   int             pixels_taken   = 0;
   int             mismatch_count = 0;
   int             send_idle_pct  = 38;
   int             recv_idle_pct  = 80;
   int             phase_target   = 0;

   always #4 clock = ~clock;

   // clamp: high bound first, low bound wins when the bounds cross
   function automatic logic [rsbl_pkg::POS_W-1:0] clamp_pos(logic [63:0] v);
      if (v >= 64'(cfg_clamp_high)) begin
         v = 64'(cfg_clamp_high);
      end
      if (v <= 64'(cfg_clamp_low)) begin
         v = 64'(cfg_clamp_low);
      end
      return v[rsbl_pkg::POS_W-1:0];
   endfunction

   // take the midpoint of the bounds, scale in Q4.12 at full width, then clamp
   function automatic logic [rsbl_pkg::POS_W-1:0] scaled_centre(
         logic [rsbl_pkg::COORD_W-1:0] lo,
         logic [rsbl_pkg::COORD_W-1:0] hi,
         logic [rsbl_pkg::SCALE_W-1:0] scale);
      logic [63:0] mid;
      mid = (64'(lo) + 64'(hi)) >> 1;
      return clamp_pos((mid * 64'(scale)) >> rsbl_pkg::SCALE_FRAC_BITS);
   endfunction

   // classify one pixel, grow the box and emit the spot at frame end
   function automatic void track_pixel(pixel_item_type p);
      logic [rsbl_pkg::COORD_W-1:0] row;
      logic [rsbl_pkg::COORD_W-1:0] col;
      logic                         red_hit;
      spot_type                     spot;
      row = p.row;
      col = p.col;
      if (int'(row) > rsbl_pkg::MAX_HEIGHT - 1) begin
         row = rsbl_pkg::COORD_W'(rsbl_pkg::MAX_HEIGHT - 1);
      end
      if (int'(col) > rsbl_pkg::MAX_WIDTH - 1) begin
         col = rsbl_pkg::COORD_W'(rsbl_pkg::MAX_WIDTH - 1);
      end
      red_hit = (int'(p.red) > int'(p.blue) + int'(cfg_diff)) &&
                (int'(p.red) > int'(p.green) + int'(cfg_diff)) &&
                (p.green < cfg_dark) && (p.blue < cfg_dark);
      if (red_hit) begin
         if (!box_seen) begin
            box_min_row = row;
            box_max_row = row;
            box_min_col = col;
            box_max_col = col;
            box_seen    = 1'b1;
         end else begin
            if (row < box_min_row) box_min_row = row;
            if (col < box_min_col) box_min_col = col;
            if (row > box_max_row) box_max_row = row;
            if (col > box_max_col) box_max_col = col;
         end
      end
      if (p.last) begin
         if (box_seen) begin
            prev_x = scaled_centre(box_min_col, box_max_col, cfg_scale_x);
            prev_y = scaled_centre(box_min_row, box_max_row, cfg_scale_y);
         end else begin
            prev_x = clamp_pos(64'(prev_x));
            prev_y = clamp_pos(64'(prev_y));
         end
         spot.pos_x = prev_x;
         spot.pos_y = prev_y;
         spot.found = box_seen;
         expected_spots.push_back(spot);
         box_min_row = '1;
         box_min_col = '1;
         box_max_row = '0;
         box_max_col = '0;
         box_seen    = 1'b0;
      end
   endfunction

   function automatic int clip(int v, int hi);
      return (v < 0) ? 0 : ((v > hi) ? hi : v);
   endfunction

   task automatic queue_pixel(int b, int g, int r, int row, int col, bit last);
      pixel_item_type p;
      p.blue  = rsbl_pkg::PIX_W'(b);
      p.green = rsbl_pkg::PIX_W'(g);
      p.red   = rsbl_pkg::PIX_W'(r);
      p.row   = rsbl_pkg::COORD_W'(row);
      p.col   = rsbl_pkg::COORD_W'(col);
      p.last  = last;
      pending_pixels.push_back(p);
      pixels_queued++;
   endtask

   // one frame: mostly red or near-threshold pixels clustered round a spot, some noise
   task automatic queue_random_frame();
      int len, spot_row, spot_col, kind, b, g, r, m, row, col;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
      spot_row = $urandom_range(0, 2047);
      spot_col = $urandom_range(0, 2047);
      for (int i = 0; i < len; i++) begin
         kind = $urandom_range(0, 99);
         b = $urandom_range(0, 255);
         g = $urandom_range(0, 255);
         r = $urandom_range(0, 255);
         if (kind < 60 && cfg_dark > 0) begin
            b = $urandom_range(0, cfg_dark - 1);
            g = $urandom_range(0, cfg_dark - 1);
            if (kind >= 45) begin
               // straddle the dark and difference thresholds
               b = clip(int'(cfg_dark) - int'($urandom_range(0, 1)), 255);
            end
            m = (b > g) ? b : g;
            if (kind < 45) begin
               if (m + cfg_diff < 255) begin
                  r = $urandom_range(m + cfg_diff + 1, 255);
               end
            end else begin
               r = clip(m + cfg_diff + int'($urandom_range(0, 1)), 255);
            end
         end
         if ($urandom_range(0, 9) < 7) begin
            row = clip(spot_row + int'($urandom_range(0, 40)) - 20, 2047);
            col = clip(spot_col + int'($urandom_range(0, 40)) - 20, 2047);
         end else begin
            row = $urandom_range(0, 2047);
            col = $urandom_range(0, 2047);
         end
         queue_pixel(b, g, r, row, col, i == len - 1);
      end
   endtask

   task automatic write_reg(rsbl_pkg::csr_index_type idx, int value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= rsbl_pkg::CSR_DATA_W'(value);
      case (idx)
         rsbl_pkg::CSR_DIFF_THRESHOLD: cfg_diff       = rsbl_pkg::PIX_W'(value);
         rsbl_pkg::CSR_DARK_THRESHOLD: cfg_dark       = rsbl_pkg::PIX_W'(value);
         rsbl_pkg::CSR_SCALE_X:        cfg_scale_x    = rsbl_pkg::SCALE_W'(value);
         rsbl_pkg::CSR_SCALE_Y:        cfg_scale_y    = rsbl_pkg::SCALE_W'(value);
         rsbl_pkg::CSR_CLAMP_LOW:      cfg_clamp_low  = rsbl_pkg::POS_W'(value);
         rsbl_pkg::CSR_CLAMP_HIGH:     cfg_clamp_high = rsbl_pkg::POS_W'(value);
         default: ;
      endcase
   endtask

   task automatic apply_config(int diff, int dark, int sx, int sy, int lo, int hi);
      write_reg(rsbl_pkg::CSR_DIFF_THRESHOLD, diff);
      write_reg(rsbl_pkg::CSR_DARK_THRESHOLD, dark);
      write_reg(rsbl_pkg::CSR_SCALE_X, sx);
      write_reg(rsbl_pkg::CSR_SCALE_Y, sy);
      write_reg(rsbl_pkg::CSR_CLAMP_LOW, lo);
      write_reg(rsbl_pkg::CSR_CLAMP_HIGH, hi);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // wait until every pixel is taken and every spot checked, then let the pipe empty
   task automatic drain_results();
      while (pixels_taken != pixels_queued || expected_spots.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
   endtask

   // pixel driver: hold an item until taken, idle at random between items
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            drive_pixel = pending_pixels.pop_front();
            req_ch.valid      <= 1'b1;
            req_ch.blue       <= drive_pixel.blue;
            req_ch.green      <= drive_pixel.green;
            req_ch.red        <= drive_pixel.red;
            req_ch.pix_row    <= drive_pixel.row;
            req_ch.pix_col    <= drive_pixel.col;
            req_ch.frame_last <= drive_pixel.last;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // track each pixel the block takes
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         taken_pixel.blue  = req_ch.blue;
         taken_pixel.green = req_ch.green;
         taken_pixel.red   = req_ch.red;
         taken_pixel.row   = req_ch.pix_row;
         taken_pixel.col   = req_ch.pix_col;
         taken_pixel.last  = req_ch.frame_last;
         track_pixel(taken_pixel);
         pixels_taken++;
      end
   end

   // spot monitor: check each result item against the oldest expected spot
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_spots.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("unexpected spot: pos_x=%0d pos_y=%0d spot_found=%0b",
                           rsp_ch.pos_x, rsp_ch.pos_y, rsp_ch.spot_found);
               end
            end else begin
               wanted_spot = expected_spots.pop_front();
               if (rsp_ch.pos_x !== wanted_spot.pos_x ||
                   rsp_ch.pos_y !== wanted_spot.pos_y ||
                   rsp_ch.spot_found !== wanted_spot.found) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("spot mismatch: expected x=%0d y=%0d found=%0b,",
                              wanted_spot.pos_x, wanted_spot.pos_y, wanted_spot.found,
                              " got x=%0d y=%0d found=%0b",
                              rsp_ch.pos_x, rsp_ch.pos_y, rsp_ch.spot_found);
                  end
               end
            end
         end
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   initial begin
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_index         = rsbl_pkg::CSR_DIFF_THRESHOLD;
      csr_wdata         = '0;
      req_ch.valid      = 1'b0;
      req_ch.blue       = '0;
      req_ch.green      = '0;
      req_ch.red        = '0;
      req_ch.pix_row    = '0;
      req_ch.pix_col    = '0;
      req_ch.frame_last = 1'b0;
      rsp_ch.ready      = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset settings: lone red pixel at the origin still counts as found
      queue_pixel(0, 0, 255, 0, 0, 1);
      // nothing red: previous position comes back
      queue_pixel(255, 255, 255, 2047, 2047, 1);
      // threshold edges; a red last pixel closes the box
      queue_pixel(99, 99, 180, 10, 300, 0);
      queue_pixel(0, 100, 255, 2047, 2047, 0);
      queue_pixel(100, 0, 255, 2047, 0, 0);
      queue_pixel(20, 0, 100, 0, 0, 0);
      queue_pixel(0, 20, 100, 0, 2047, 0);
      queue_pixel(0, 0, 200, 200, 100, 1);
      drain_results();

      // widest thresholds and largest scale: products far beyond 12 bits
      apply_config(0, 255, 65535, 65535, 0, 4095);
      queue_pixel(254, 254, 255, 2047, 2047, 1);
      queue_pixel(255, 0, 255, 0, 0, 1);
      queue_pixel(0, 0, 1, 0, 2047, 0);
      queue_pixel(0, 0, 0, 1024, 1024, 0);
      queue_pixel(0, 0, 1, 2047, 0, 1);
      drain_results();

      // crossed clamp bounds: the low bound wins
      apply_config(80, 100, 4096, 0, 300, 100);
      queue_pixel(255, 255, 0, 5, 5, 1);
      queue_pixel(0, 0, 255, 5, 2047, 1);
      drain_results();

      // random frames over a spread of settings and idling patterns
      for (int phase = 0; phase < 6; phase++) begin
         if (phase < 2) begin
            send_idle_pct = 38;
            recv_idle_pct = 80;
         end else if (phase < 4) begin
            send_idle_pct = 80;
            recv_idle_pct = 38;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (phase)
            0: apply_config(80, 100, 4096, 4096, 20, 380);
            1: apply_config(0, 255, 65535, 65535, 0, 4095);
            2: apply_config(255, 0, 0, 0, 0, 0);
            3: apply_config($urandom_range(0, 120), $urandom_range(40, 255),
                            $urandom_range(0, 65535), $urandom_range(0, 65535),
                            $urandom_range(0, 300), $urandom_range(300, 4095));
            4: apply_config(30, 200, 1000, 50000, 1000, 900);
            default: apply_config($urandom_range(0, 255), $urandom_range(0, 255),
                                  $urandom_range(0, 65535), $urandom_range(0, 65535),
                                  $urandom_range(0, 4095), $urandom_range(0, 4095));
         endcase
         phase_target = pixels_queued + 205;
         while (pixels_queued < phase_target) begin
            queue_random_frame();
         end
         drain_results();
      end

      if (mismatch_count == 0 && expected_spots.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // hard stop if the handshakes hang
   initial begin
      #2000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

FILE: files.f
sv/rsbl_pkg.sv
sv/rsbl_req_if.sv
sv/rsbl_rsp_if.sv
sv/rsbl_csr.sv
sv/rsbl_box.sv
sv/rsbl_scale.sv
sv/red_spot_bbox_locator.sv
verif/red_spot_bbox_locator_tb.sv
